// File: src/circumcircle_incircle_test_assert.svh
// ----------------------------------------------------------------------------
// Circumcircle test assertion macros
// Shared property shorthands for the checker, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCUMCIRCLE_INCIRCLE_TEST_ASSERT_SVH
`define CIRCUMCIRCLE_INCIRCLE_TEST_ASSERT_SVH

// same-cycle implication
`define CIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cit_pkg.sv
// ----------------------------------------------------------------------------
// Circumcircle test package
// Field widths, codes and payload structs shared by the pipeline modules.
// ----------------------------------------------------------------------------
package cit_pkg;

  localparam int CW        = 16;          // coordinate width
  localparam int CB        = 48;          // center width
  localparam int RB        = 63;          // squared radius width
  localparam int EW        = 16;          // epsilon width
  localparam int DM        = 2 * CW + 5;  // determinant width
  localparam int NM        = 3 * CW + 5;  // numerator width

  localparam logic [EW-1:0] EPS_RESET = 16'd1;

  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_CCW = 2'd1;
  localparam logic [1:0] ORI_CW  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
  } cit_in_t;

  typedef struct packed {
    logic signed [CB-1:0] center_x;
    logic signed [CB-1:0] center_y;
    logic [RB-1:0]        radius_sq;
    logic                 inside_res;
    logic [1:0]           orientation;
    logic                 degenerate;
  } cit_out_t;

  typedef struct packed {
    logic [1:0]           orientation;
    logic                 degenerate;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
  } cit_side_t;

  typedef struct packed {
    cit_side_t    side;
    logic [NM-1:0] num_x;
    logic [NM-1:0] num_y;
    logic [DM-1:0] den;
  } cit_front_t;

endpackage

// File: src/cit_front.sv
// ----------------------------------------------------------------------------
// Circumcircle test front end
// Five stages: differences and squares, area terms, products, determinant
// and numerators, then magnitudes and quotient signs for the dividers.
// ----------------------------------------------------------------------------
module cit_front import cit_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  cit_in_t    in_data,
  output cit_front_t front_data
);

  localparam int SW = 2 * CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int KW = 3 * CW + 3;
  localparam int AW = 2 * CW + 3;

  // stage 1
  logic signed [2*CW-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [CW:0]     dxab_r, dyab_r, dxac_r, dyac_r, ebc_r, eca_r, eab_r;
  logic signed [SW-1:0]   sa_r, sb_r, sc_r;
  logic signed [CW-1:0]   ax1_r, ay1_r, bx1_r, cx1_r, qx1_r, qy1_r;
  // stage 2
  logic signed [SW:0]     c1_r, c2_r;
  logic signed [PW-1:0]   t1_r, t2_r, t3_r;
  logic signed [CW:0]     dxab2_r, dyab2_r, dxac2_r, dyac2_r;
  logic signed [CW-1:0]   ax2_r, ay2_r, qx2_r, qy2_r;
  // stage 3
  logic signed [PW-1:0]   p1_r, p2_r;
  logic signed [KW-1:0]   p3_r, p4_r, p5_r, p6_r;
  logic signed [AW-1:0]   area_r;
  logic signed [CW-1:0]   ax3_r, ay3_r, qx3_r, qy3_r;
  // stage 4
  logic signed [DM-1:0]   det_r;
  logic signed [NM-1:0]   numx_r, numy_r;
  logic [1:0]             ori_r;
  logic signed [CW-1:0]   ax4_r, ay4_r, qx4_r, qy4_r;
  // stage 5
  cit_front_t             front_r;

  assign sq_ax = (2*CW)'(in_data.a_x) * (2*CW)'(in_data.a_x);
  assign sq_ay = (2*CW)'(in_data.a_y) * (2*CW)'(in_data.a_y);
  assign sq_bx = (2*CW)'(in_data.b_x) * (2*CW)'(in_data.b_x);
  assign sq_by = (2*CW)'(in_data.b_y) * (2*CW)'(in_data.b_y);
  assign sq_cx = (2*CW)'(in_data.c_x) * (2*CW)'(in_data.c_x);
  assign sq_cy = (2*CW)'(in_data.c_y) * (2*CW)'(in_data.c_y);

  always_ff @(posedge clk) begin
    if (en) begin
      dxab_r <= (CW+1)'(in_data.a_x) - (CW+1)'(in_data.b_x);
      dyab_r <= (CW+1)'(in_data.a_y) - (CW+1)'(in_data.b_y);
      dxac_r <= (CW+1)'(in_data.a_x) - (CW+1)'(in_data.c_x);
      dyac_r <= (CW+1)'(in_data.a_y) - (CW+1)'(in_data.c_y);
      ebc_r  <= (CW+1)'(in_data.b_y) - (CW+1)'(in_data.c_y);
      eca_r  <= (CW+1)'(in_data.c_y) - (CW+1)'(in_data.a_y);
      eab_r  <= (CW+1)'(in_data.a_y) - (CW+1)'(in_data.b_y);
      sa_r   <= SW'(sq_ax) + SW'(sq_ay);
      sb_r   <= SW'(sq_bx) + SW'(sq_by);
      sc_r   <= SW'(sq_cx) + SW'(sq_cy);
      ax1_r  <= in_data.a_x;
      ay1_r  <= in_data.a_y;
      bx1_r  <= in_data.b_x;
      cx1_r  <= in_data.c_x;
      qx1_r  <= in_data.q_x;
      qy1_r  <= in_data.q_y;

      c1_r    <= (SW+1)'(sa_r) - (SW+1)'(sb_r);
      c2_r    <= (SW+1)'(sa_r) - (SW+1)'(sc_r);
      t1_r    <= PW'(ax1_r) * PW'(ebc_r);
      t2_r    <= PW'(bx1_r) * PW'(eca_r);
      t3_r    <= PW'(cx1_r) * PW'(eab_r);
      dxab2_r <= dxab_r;
      dyab2_r <= dyab_r;
      dxac2_r <= dxac_r;
      dyac2_r <= dyac_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      qx2_r   <= qx1_r;
      qy2_r   <= qy1_r;

      p1_r   <= PW'(dxab2_r) * PW'(dyac2_r);
      p2_r   <= PW'(dxac2_r) * PW'(dyab2_r);
      p3_r   <= KW'(c2_r) * KW'(dyab2_r);
      p4_r   <= KW'(c1_r) * KW'(dyac2_r);
      p5_r   <= KW'(dxac2_r) * KW'(c1_r);
      p6_r   <= KW'(dxab2_r) * KW'(c2_r);
      area_r <= AW'(t1_r) + AW'(t2_r) + AW'(t3_r);
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      qx3_r  <= qx2_r;
      qy3_r  <= qy2_r;

      // det = 4(p1-p2), numerators carry the -2 factor of the bisector lines
      det_r  <= (DM'(p1_r) - DM'(p2_r)) <<< 2;
      numx_r <= -((NM'(p3_r) - NM'(p4_r)) <<< 1);
      numy_r <= -((NM'(p5_r) - NM'(p6_r)) <<< 1);
      if (area_r[AW-1]) begin
        ori_r <= ORI_CW;
      end else if (area_r != '0) begin
        ori_r <= ORI_CCW;
      end else begin
        ori_r <= ORI_COL;
      end
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;
      qx4_r <= qx3_r;
      qy4_r <= qy3_r;

      front_r.den              <= det_r[DM-1] ? DM'(-det_r) : DM'(det_r);
      front_r.num_x            <= numx_r[NM-1] ? NM'(-numx_r) : NM'(numx_r);
      front_r.num_y            <= numy_r[NM-1] ? NM'(-numy_r) : NM'(numy_r);
      front_r.side.neg_x       <= numx_r[NM-1] ^ det_r[DM-1];
      front_r.side.neg_y       <= numy_r[NM-1] ^ det_r[DM-1];
      front_r.side.degenerate  <= (det_r == '0);
      front_r.side.orientation <= ori_r;
      front_r.side.a_x         <= ax4_r;
      front_r.side.a_y         <= ay4_r;
      front_r.side.q_x         <= qx4_r;
      front_r.side.q_y         <= qy4_r;
    end
  end

  assign front_data = front_r;

endmodule

// File: src/cit_div.sv
// ----------------------------------------------------------------------------
// Circumcircle test divider
// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags a quotient that cannot fit the center width.
// ----------------------------------------------------------------------------
module cit_div import cit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NM-1:0] num,
  input  logic [DM-1:0] den,
  output logic [CB-1:0] quo,
  output logic          ovf
);

  localparam int DVW = NM + FRAC_BITS;
  localparam int TW  = DVW - CB;

  logic [DVW-1:0] dvd;
  logic [TW-1:0]  top_w;
  logic [DM-1:0]  rem_r [0:CB];
  logic [DM-1:0]  den_r [0:CB];
  logic [CB-1:0]  low_r [0:CB];
  logic [CB-1:0]  q_r   [0:CB];
  logic           ovf_r [0:CB];
  logic [DM:0]    trial [0:CB-1];
  logic           ge    [0:CB-1];

  assign dvd   = {num, {FRAC_BITS{1'b0}}};
  assign top_w = dvd[DVW-1:CB];

  always_comb begin
    for (int k = 0; k < CB; k++) begin
      trial[k] = {rem_r[k], low_r[k][CB-1-k]};
      ge[k]    = trial[k] >= {1'b0, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // upper dividend bits at or above the divisor mean the quotient overflows
      rem_r[0] <= DM'(top_w);
      den_r[0] <= den;
      low_r[0] <= dvd[CB-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= DM'(top_w) >= den;
      for (int k = 0; k < CB; k++) begin
        rem_r[k+1] <= ge[k] ? DM'(trial[k] - {1'b0, den_r[k]}) : trial[k][DM-1:0];
        den_r[k+1] <= den_r[k];
        low_r[k+1] <= low_r[k];
        q_r[k+1]   <= {q_r[k][CB-2:0], ge[k]};
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = q_r[CB];
  assign ovf = ovf_r[CB];

endmodule

// File: src/cit_dist.sv
// ----------------------------------------------------------------------------
// Circumcircle test distance back end
// Saturates the centers, forms squared distances to A and Q through split
// multiplies, then saturates the radius and runs the tolerance compare.
// ----------------------------------------------------------------------------
module cit_dist import cit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          en,
  input  cit_side_t     side,
  input  logic [CB-1:0] quo_x,
  input  logic [CB-1:0] quo_y,
  input  logic          ovf_x,
  input  logic          ovf_y,
  input  logic [EW-1:0] eps,
  output cit_out_t      out_data
);

  localparam int MW   = CB + 1;
  localparam int LW   = (MW + 1) / 2;
  localparam int HW   = MW - LW;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 1;

  function automatic logic signed [CB-1:0] sat_center(input logic [CB-1:0] q,
                                                       input logic ovf_i,
                                                       input logic neg);
    logic                 sat;
    logic signed [CB-1:0] res;
    if (neg) begin
      sat = ovf_i | (q[CB-1] & (|q[CB-2:0]));
      res = sat ? {1'b1, {(CB-1){1'b0}}} : -$signed(q);
    end else begin
      sat = ovf_i | q[CB-1];
      res = sat ? {1'b0, {(CB-1){1'b1}}} : $signed(q);
    end
    return res;
  endfunction

  function automatic logic [MW-1:0] mag_diff(input logic signed [CB-1:0] o,
                                             input logic signed [CW-1:0] p);
    logic signed [MW-1:0] ps;
    logic signed [MW-1:0] diff;
    ps   = MW'(p) <<< FRAC_BITS;
    diff = MW'(o) - ps;
    return diff[MW-1] ? MW'(-diff) : MW'(diff);
  endfunction

  logic signed [CB-1:0] ox1_r, oy1_r, ox2_r, oy2_r, ox3_r, oy3_r, ox4_r, oy4_r;
  logic signed [CB-1:0] ox5_r, oy5_r;
  logic signed [CW-1:0] ax1_r, ay1_r, qx1_r, qy1_r;
  logic [1:0]           ori1_r, ori2_r, ori3_r, ori4_r, ori5_r;
  logic                 dgn1_r, dgn2_r, dgn3_r, dgn4_r, dgn5_r;
  logic [MW-1:0]        mag2_r [0:3];
  logic [2*HW-1:0]      hh3_r  [0:3];
  logic [HW+LW-1:0]     hl3_r  [0:3];
  logic [2*LW-1:0]      ll3_r  [0:3];
  logic [SQW-1:0]       sq4_r  [0:3];
  logic [SUMW-1:0]      ra5_r, rq5_r;
  logic [RB-1:0]        rad;
  logic [SUMW:0]        dq;
  cit_out_t             out_r;

  always_comb begin
    rad = (|ra5_r[SUMW-1:RB]) ? {RB{1'b1}} : ra5_r[RB-1:0];
    dq  = (SUMW+1)'(rq5_r) + (SUMW+1)'(eps);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // D1: saturate, zero the center of a degenerate triangle
      ox1_r  <= side.degenerate ? '0 : sat_center(quo_x, ovf_x, side.neg_x);
      oy1_r  <= side.degenerate ? '0 : sat_center(quo_y, ovf_y, side.neg_y);
      ax1_r  <= side.a_x;
      ay1_r  <= side.a_y;
      qx1_r  <= side.q_x;
      qy1_r  <= side.q_y;
      ori1_r <= side.orientation;
      dgn1_r <= side.degenerate;

      // D2: lane 0/1 to vertex A, lane 2/3 to query Q
      mag2_r[0] <= mag_diff(ox1_r, ax1_r);
      mag2_r[1] <= mag_diff(oy1_r, ay1_r);
      mag2_r[2] <= mag_diff(ox1_r, qx1_r);
      mag2_r[3] <= mag_diff(oy1_r, qy1_r);
      ox2_r  <= ox1_r;
      oy2_r  <= oy1_r;
      ori2_r <= ori1_r;
      dgn2_r <= dgn1_r;

      // D3: split squares into partial products
      for (int i = 0; i < 4; i++) begin
        hh3_r[i] <= (2*HW)'(mag2_r[i][MW-1:LW]) * (2*HW)'(mag2_r[i][MW-1:LW]);
        hl3_r[i] <= (HW+LW)'(mag2_r[i][MW-1:LW]) * (HW+LW)'(mag2_r[i][LW-1:0]);
        ll3_r[i] <= (2*LW)'(mag2_r[i][LW-1:0]) * (2*LW)'(mag2_r[i][LW-1:0]);
      end
      ox3_r  <= ox2_r;
      oy3_r  <= oy2_r;
      ori3_r <= ori2_r;
      dgn3_r <= dgn2_r;

      // D4: recombine
      for (int i = 0; i < 4; i++) begin
        sq4_r[i] <= (SQW'(hh3_r[i]) << (2 * LW)) + (SQW'(hl3_r[i]) << (LW + 1))
                    + SQW'(ll3_r[i]);
      end
      ox4_r  <= ox3_r;
      oy4_r  <= oy3_r;
      ori4_r <= ori3_r;
      dgn4_r <= dgn3_r;

      // D5: sum and drop the extra fraction bits
      ra5_r  <= (SUMW'(sq4_r[0]) + SUMW'(sq4_r[1])) >> FRAC_BITS;
      rq5_r  <= (SUMW'(sq4_r[2]) + SUMW'(sq4_r[3])) >> FRAC_BITS;
      ox5_r  <= ox4_r;
      oy5_r  <= oy4_r;
      ori5_r <= ori4_r;
      dgn5_r <= dgn4_r;

      // D6: output register
      out_r.center_x    <= ox5_r;
      out_r.center_y    <= oy5_r;
      out_r.radius_sq   <= dgn5_r ? '0 : rad;
      out_r.inside_res  <= ~dgn5_r & (dq <= (SUMW+1)'(rad));
      out_r.orientation <= ori5_r;
      out_r.degenerate  <= dgn5_r;
    end
  end

  assign out_data = out_r;

endmodule

// File: src/circumcircle_incircle_test.sv
// ----------------------------------------------------------------------------
// Triangle circumcircle and in-circle test
// Orientation, circumcenter, squared radius and in-circle flag per triangle.
// ----------------------------------------------------------------------------
// Takes one triangle plus query point per clock while in_stall is low and
// returns one result per item, in order, through 5 front stages of
// products, a 49-stage restoring divider (one center bit per stage after
// the first, x and y in parallel) and 6 back stages of distance products
// and compares. A stall on the result side holds the whole pipeline;
// in_stall is high only while a finished result sits stalled at the output.
// epsilon may only be written while no item is in flight.
module circumcircle_incircle_test import cit_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cit_in_t       in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cit_out_t      out_data,
  input  logic          cfg_wr_en,
  input  logic [EW-1:0] cfg_wr_data
);

  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = CB + 1;
  localparam int DIST_LAT  = 6;
  localparam int LAT       = FRONT_LAT + DIV_LAT + DIST_LAT;

  logic          en;
  logic [LAT-1:0] vld_r;
  logic [EW-1:0] eps_r;
  cit_front_t    front;
  cit_side_t     side_r [0:DIV_LAT-1];
  logic [CB-1:0] quo_x, quo_y;
  logic          ovf_x, ovf_y;

  assign en        = ~(vld_r[LAT-1] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      eps_r <= EPS_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
    end
  end

  // side data rides alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= front.side;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  cit_front u_front (
    .clk        (clk),
    .en         (en),
    .in_data    (in_data),
    .front_data (front)
  );

  cit_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (front.num_x),
    .den (front.den),
    .quo (quo_x),
    .ovf (ovf_x)
  );

  cit_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (front.num_y),
    .den (front.den),
    .quo (quo_y),
    .ovf (ovf_y)
  );

  cit_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
    .clk      (clk),
    .en       (en),
    .side     (side_r[DIV_LAT-1]),
    .quo_x    (quo_x),
    .quo_y    (quo_y),
    .ovf_x    (ovf_x),
    .ovf_y    (ovf_y),
    .eps      (eps_r),
    .out_data (out_data)
  );

endmodule

// File: src/cit_checker.sv
// ----------------------------------------------------------------------------
// Circumcircle test port checker
// Watches the top-level ports for handshake and degenerate-result rules.
// ----------------------------------------------------------------------------
`include "circumcircle_incircle_test_assert.svh"

module cit_checker import cit_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input cit_out_t out_data
);

  `CIT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CIT_ASSERT_IMP(a_in_free, !(out_valid && out_stall), !in_stall, "input stalled with no output stall")
  `CIT_ASSERT_IMP(a_dgn_zero, out_valid && out_data.degenerate, out_data.center_x == 0 && out_data.center_y == 0 && out_data.radius_sq == 0 && !out_data.inside_res, "degenerate result not zeroed")
  `CIT_ASSERT_IMP(a_dgn_col, out_valid && out_data.degenerate, out_data.orientation == ORI_COL, "degenerate triangle not collinear")

endmodule

bind circumcircle_incircle_test cit_checker u_cit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circumcircle and in-circle test bench
// Drives triangles with query points through the pipeline under random
// sender gaps and receiver stalls. Every result is checked against a
// circle predictor computed in wide integer arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  import cit_pkg::*;

  localparam int FRAC       = 16;
  localparam int LATENCY    = 60;
  localparam int CYCLE_MAX  = 400000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  cit_in_t       in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  cit_out_t      out_data;
  logic          cfg_wr_en = 1'b0;
  logic [EW-1:0] cfg_wr_data = '0;

  logic [EW-1:0] eps_shadow = EPS_RESET;
  cit_out_t      circle_q[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  circumcircle_incircle_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // trunc(num * 2^FRAC / den), saturated to the center width
  function automatic logic signed [CB-1:0] center_quot(logic signed [127:0] num,
                                                       longint den);
    logic [127:0] mag, dm, quo, lim;
    bit neg;
    neg = num[127] ^ (den < 0);
    mag = num[127] ? -num : num;
    dm  = (den < 0) ? -den : den;
    lim = 128'd1 << (CB - 1);
    quo = (mag << FRAC) / dm;
    if (!neg) return (quo > lim - 1) ? CB'(lim - 1) : CB'(quo);
    return (quo > lim) ? CB'(-lim) : CB'(-quo);
  endfunction

  function automatic logic [127:0] dist_sq(longint cx, longint cy, longint px, longint py);
    logic signed [127:0] dx, dy;
    dx = cx - (px <<< FRAC);
    dy = cy - (py <<< FRAC);
    return (dx * dx + dy * dy) >> FRAC;
  endfunction

  function automatic cit_out_t predict_circle(cit_in_t t, logic [EW-1:0] eps);
    longint ax, ay, bx, by, cx, cy, qx, qy, area, a1, b1, a2, b2, c1, c2, det, ox, oy;
    logic signed [127:0] nx, ny;
    logic [127:0] rad, dq, rmax;
    cit_out_t r;
    ax = t.a_x; ay = t.a_y; bx = t.b_x; by = t.b_y;
    cx = t.c_x; cy = t.c_y; qx = t.q_x; qy = t.q_y;
    r = '0;
    area = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
    r.orientation = (area > 0) ? ORI_CCW : ((area < 0) ? ORI_CW : ORI_COL);
    a1 = -2 * (ax - bx); b1 = -2 * (ay - by);
    a2 = -2 * (ax - cx); b2 = -2 * (ay - cy);
    c1 = ax * ax + ay * ay - bx * bx - by * by;
    c2 = ax * ax + ay * ay - cx * cx - cy * cy;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nx = 128'(c2) * 128'(b1) - 128'(c1) * 128'(b2);
    ny = 128'(a2) * 128'(c1) - 128'(a1) * 128'(c2);
    nx = $signed(nx); ny = $signed(ny);
    ox = center_quot(nx, det);
    oy = center_quot(ny, det);
    rmax = (128'd1 << RB) - 1;
    rad = dist_sq(ox, oy, ax, ay);
    if (rad > rmax) rad = rmax;
    dq = dist_sq(ox, oy, qx, qy) + eps;
    r.center_x = ox[CB-1:0];
    r.center_y = oy[CB-1:0];
    r.radius_sq = rad[RB-1:0];
    r.inside_res = (dq <= rad);
    return r;
  endfunction

  // receiver stall pattern: switches mode now and then, including no stalls
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    cit_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (circle_q.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        exp_r = circle_q.pop_front();
        if (out_data.center_x !== exp_r.center_x) begin
          $error("center_x exp %0d got %0d", exp_r.center_x, out_data.center_x);
          fail_count++;
        end
        if (out_data.center_y !== exp_r.center_y) begin
          $error("center_y exp %0d got %0d", exp_r.center_y, out_data.center_y);
          fail_count++;
        end
        if (out_data.radius_sq !== exp_r.radius_sq) begin
          $error("radius_sq exp %0d got %0d", exp_r.radius_sq, out_data.radius_sq);
          fail_count++;
        end
        if (out_data.inside_res !== exp_r.inside_res) begin
          $error("inside_res exp %0d got %0d", exp_r.inside_res, out_data.inside_res);
          fail_count++;
        end
        if (out_data.orientation !== exp_r.orientation) begin
          $error("orientation exp %0d got %0d", exp_r.orientation, out_data.orientation);
          fail_count++;
        end
        if (out_data.degenerate !== exp_r.degenerate) begin
          $error("degenerate exp %0d got %0d", exp_r.degenerate, out_data.degenerate);
          fail_count++;
        end
      end
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_triangle(cit_in_t t);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    circle_q.push_back(predict_circle(t, eps_shadow));
    burst_left--;
  endtask

  task automatic drain_pipe;
    in_valid <= 1'b0;
    burst_left = 0;
    while (circle_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [EW-1:0] val);
    drain_pipe();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eps_shadow = val;
    @(posedge clk);
  endtask

  function automatic cit_in_t mk(int ax, int ay, int bx, int by,
                                 int cx, int cy, int qx, int qy);
    cit_in_t t;
    t.a_x = CW'(ax); t.a_y = CW'(ay); t.b_x = CW'(bx); t.b_y = CW'(by);
    t.c_x = CW'(cx); t.c_y = CW'(cy); t.q_x = CW'(qx); t.q_y = CW'(qy);
    return t;
  endfunction

  function automatic int coord_pick(int span);
    if (span == 0) return $signed(16'($urandom()));
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic cit_in_t rand_triangle;
    cit_in_t t;
    int span;
    int v;
    case ($urandom_range(0, 3))
      0: span = 0;
      1: span = 30;
      2: span = 1000;
      default: span = 20000;
    endcase
    t = mk(coord_pick(span), coord_pick(span), coord_pick(span), coord_pick(span),
           coord_pick(span), coord_pick(span), coord_pick(span), coord_pick(span));
    case ($urandom_range(0, 5))
      // query close to a vertex: lands near the circle boundary
      0, 1: begin
        v = $urandom_range(0, 4) - 2;
        t.q_x = t.a_x + 16'(v);
        t.q_y = t.a_y + 16'($urandom_range(0, 4) - 2);
      end
      2: begin
        t.q_x = (t.a_x + t.b_x) >>> 1;
        t.q_y = (t.a_y + t.c_y) >>> 1;
      end
      // collinear or repeated vertex
      3: if ($urandom_range(0, 3) == 0) begin
        t.c_x = t.b_x; t.c_y = t.b_y;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic test_directed;
    send_triangle(mk(0, 0, 4, 0, 0, 4, 1, 1));
    send_triangle(mk(0, 0, 0, 4, 4, 0, 5, 5));
    send_triangle(mk(0, 0, 2, 2, 4, 4, 1, 1));
    send_triangle(mk(7, 7, 7, 7, 7, 7, 7, 7));
    send_triangle(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_triangle(mk(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
    send_triangle(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_triangle(mk(-32768, -32768, 32767, 32767, 32767, 32766, 0, 0));
    send_triangle(mk(-32768, -32767, 32767, 32767, -32767, -32766, 32767, -32768));
    send_triangle(mk(0, 0, 6, 0, 0, 8, 0, 0));
    send_triangle(mk(0, 0, 6, 0, 0, 8, 6, 8));
    send_triangle(mk(0, 0, 6, 0, 0, 8, 3, 4));
    send_triangle(mk(0, 0, 1, 0, 0, 1, 0, 0));
    send_triangle(mk(1, 0, 0, 1, 0, 0, -32768, 32767));
    send_triangle(mk(-3, 5, 11, -7, 2, 9, 1, 1));
    send_triangle(mk(32767, 0, -32768, 0, 0, 1, 0, -32768));
  endtask

  task automatic test_epsilon_sweep;
    write_epsilon(16'd0);
    send_triangle(mk(0, 0, 6, 0, 0, 8, 6, 8));
    send_triangle(mk(0, 0, 1, 0, 0, 1, 1, 1));
    write_epsilon(16'hFFFF);
    send_triangle(mk(0, 0, 6, 0, 0, 8, 6, 8));
    send_triangle(mk(0, 0, 1, 0, 0, 1, 0, 0));
    send_triangle(mk(0, 0, 2, 0, 0, 2, 1, 1));
  endtask

  task automatic test_random(int count);
    repeat (count) send_triangle(rand_triangle());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_epsilon_sweep();
    write_epsilon(EPS_RESET);
    test_random(150);
    write_epsilon(16'hFFFF);
    test_random(100);
    write_epsilon(16'd0);
    test_random(100);
    write_epsilon(16'($urandom()));
    test_random(100);
    drain_pipe();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
